@@ sv/mfe_pkg.sv @@
package mfe_pkg;

   localparam logic [7:0]  MARK_V1  = 8'hFE;
   localparam logic [7:0]  MARK_V2  = 8'hFD;
   localparam logic [15:0] CRC_SEED = 16'hFFFF;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROTOCOL_VERSION = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYSTEM_ID        = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COMPONENT_ID     = 2'd2;

   localparam logic       RESET_PROTOCOL_VERSION = 1'b0;
   localparam logic [7:0] RESET_SYSTEM_ID        = 8'd255;
   localparam logic [7:0] RESET_COMPONENT_ID     = 8'd190;

   // one wire byte of a frame
   typedef enum logic [3:0] {
      ST_MARK,
      ST_LEN,
      ST_INCOMPAT,
      ST_COMPAT,
      ST_SEQ,
      ST_SYS,
      ST_COMP,
      ST_ID0,
      ST_ID1,
      ST_ID2,
      ST_PAYLOAD,
      ST_CRC_LO,
      ST_CRC_HI
   } step_type;

endpackage

@@ sv/mfe_req_if.sv @@
interface mfe_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  payload_byte;
   logic [7:0]  payload_length;
   logic [23:0] message_id;
   logic [7:0]  checksum_extra;
   logic        last_byte;

   modport source (
      output valid, payload_byte, payload_length, message_id, checksum_extra, last_byte,
      input  ready
   );
   modport sink (
      input  valid, payload_byte, payload_length, message_id, checksum_extra, last_byte,
      output ready
   );
endinterface

@@ sv/mfe_rsp_if.sv @@
interface mfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (
      output valid, frame_byte, frame_end,
      input  ready
   );
   modport sink (
      input  valid, frame_byte, frame_end,
      output ready
   );
endinterface

@@ sv/mfe_crc16.sv @@
module mfe_crc16 (
   input  logic [15:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [15:0] crc_next
);
   logic [7:0] t0;
   logic [7:0] t1;

   // mcrf4xx byte update, reflected polynomial 0x8408
   assign t0 = data_byte ^ crc_cur[7:0];
   assign t1 = t0 ^ {t0[3:0], 4'b0000};
   assign crc_next = {8'h00, crc_cur[15:8]} ^ {t1, 8'h00} ^ {5'b00000, t1, 3'b000}
                   ^ {12'h000, t1[7:4]};
endmodule

@@ sv/mavlink_frame_encoder_core.sv @@
// Byte-serial MAVLink framer. Each request transaction carries one payload byte;
// the block sends one wire byte per cycle from its single response register, and
// inside a frame payload streams at one byte per cycle, unless the output stalls.
// The first byte of a frame is preceded by the header: marker, length, two flag
// bytes (version 2 only), sequence, system and component IDs, and message ID (one
// byte in version 1, three in version 2). The byte marked last is followed by the
// little-endian CRC-16/MCRF4XX (seed 0xFFFF, over every byte after the start
// marker, closed with the extra checksum byte). The request register holds while
// header or checksum bytes of its item are still going out. Configuration is read
// at header time and should be written only while no transaction is in flight; a
// write after the header of an open frame takes effect at the next header.
module mavlink_frame_encoder_core (
   input  logic                                clock,
   input  logic                                reset,
   mfe_req_if.sink                             req_chan,
   mfe_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [mfe_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mfe_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import mfe_pkg::*;

   logic       version_ff;
   logic [7:0] system_id_ff;
   logic [7:0] component_id_ff;

   logic        item_valid_ff;
   logic        fresh_ff;
   logic [7:0]  pbyte_ff;
   logic [7:0]  plen_ff;
   logic [23:0] msgid_ff;
   logic [7:0]  extra_ff;
   logic        last_ff;

   step_type    step_ff;
   step_type    step_in;
   step_type    cur_step;
   logic        in_frame_ff;
   logic [7:0]  seq_ff;
   logic [15:0] crc_ff;
   logic [15:0] crc_next;
   logic [7:0]  crc_data;

   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_end_ff;

   logic       emit;
   logic       done;
   logic       load;
   logic [7:0] out_byte;
   logic       out_end;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff      <= RESET_PROTOCOL_VERSION;
         system_id_ff    <= RESET_SYSTEM_ID;
         component_id_ff <= RESET_COMPONENT_ID;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PROTOCOL_VERSION: version_ff      <= csr_wdata[0];
            CSR_SYSTEM_ID:        system_id_ff    <= csr_wdata;
            CSR_COMPONENT_ID:     component_id_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // first step of an item depends on whether a frame is already open
   assign cur_step = fresh_ff ? (in_frame_ff ? ST_PAYLOAD : ST_MARK) : step_ff;

   assign emit = item_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign done = emit && ((cur_step == ST_PAYLOAD && !last_ff) || cur_step == ST_CRC_HI);
   assign load = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !item_valid_ff || done;

   mfe_crc16 u_crc (
      .crc_cur   (crc_ff),
      .data_byte (crc_data),
      .crc_next  (crc_next)
   );

   // crc_data is the byte folded into the checksum; on header and payload steps
   // it is also the wire byte
   always_comb begin
      out_end = 1'b0;
      step_in = cur_step;
      unique case (cur_step)
         ST_MARK: begin
            crc_data = version_ff ? MARK_V2 : MARK_V1;
            step_in  = ST_LEN;
         end
         ST_LEN: begin
            crc_data = plen_ff;
            step_in  = version_ff ? ST_INCOMPAT : ST_SEQ;
         end
         ST_INCOMPAT: begin
            crc_data = 8'h00;
            step_in  = ST_COMPAT;
         end
         ST_COMPAT: begin
            crc_data = 8'h00;
            step_in  = ST_SEQ;
         end
         ST_SEQ: begin
            crc_data = seq_ff;
            step_in  = ST_SYS;
         end
         ST_SYS: begin
            crc_data = system_id_ff;
            step_in  = ST_COMP;
         end
         ST_COMP: begin
            crc_data = component_id_ff;
            step_in  = ST_ID0;
         end
         ST_ID0: begin
            crc_data = msgid_ff[7:0];
            step_in  = version_ff ? ST_ID1 : ST_PAYLOAD;
         end
         ST_ID1: begin
            crc_data = msgid_ff[15:8];
            step_in  = ST_ID2;
         end
         ST_ID2: begin
            crc_data = msgid_ff[23:16];
            step_in  = ST_PAYLOAD;
         end
         ST_PAYLOAD: begin
            crc_data = pbyte_ff;
            step_in  = ST_CRC_LO;
         end
         ST_CRC_LO: begin
            crc_data = extra_ff;
            step_in  = ST_CRC_HI;
         end
         ST_CRC_HI: begin
            crc_data = extra_ff;
            out_end  = 1'b1;
         end
         default: begin
            crc_data = 8'h00;
         end
      endcase
   end

   always_comb begin
      unique case (cur_step)
         ST_CRC_LO: out_byte = crc_next[7:0];
         ST_CRC_HI: out_byte = crc_next[15:8];
         default:   out_byte = crc_data;
      endcase
   end

   // request holding register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         fresh_ff      <= 1'b0;
      end else if (load) begin
         item_valid_ff <= 1'b1;
         fresh_ff      <= 1'b1;
      end else begin
         if (done) item_valid_ff <= 1'b0;
         if (emit) fresh_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pbyte_ff <= req_chan.payload_byte;
         plen_ff  <= req_chan.payload_length;
         msgid_ff <= req_chan.message_id;
         extra_ff <= req_chan.checksum_extra;
         last_ff  <= req_chan.last_byte;
      end
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= ST_MARK;
         in_frame_ff <= 1'b0;
         seq_ff      <= 8'h00;
         crc_ff      <= CRC_SEED;
      end else if (emit) begin
         step_ff <= step_in;
         case (cur_step)
            ST_MARK: begin
               in_frame_ff <= 1'b1;
               crc_ff      <= CRC_SEED;
            end
            ST_CRC_LO: ;
            ST_CRC_HI: begin
               in_frame_ff <= 1'b0;
               crc_ff      <= CRC_SEED;
            end
            default: crc_ff <= crc_next;
         endcase
         if (cur_step == ST_SEQ) seq_ff <= seq_ff + 8'd1;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff <= out_byte;
         rsp_end_ff  <= out_end;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.frame_byte = rsp_byte_ff;
   assign rsp_chan.frame_end  = rsp_end_ff;

   a_crc_idle_seed: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> crc_ff == CRC_SEED)
      else $error("checksum not at seed outside a frame");

   a_mark_only_idle: assert property (@(posedge clock) disable iff (reset)
      (emit && cur_step == ST_MARK) |-> !in_frame_ff)
      else $error("start marker sent inside an open frame");

   a_close_frame: assert property (@(posedge clock) disable iff (reset)
      (emit && cur_step == ST_CRC_HI) |=> !in_frame_ff && rsp_chan.valid && rsp_chan.frame_end)
      else $error("frame not closed after high checksum byte");

   a_seq_advance: assert property (@(posedge clock) disable iff (reset)
      (emit && cur_step == ST_SEQ) |=> seq_ff == $past(seq_ff) + 8'd1)
      else $error("sequence number did not advance once per header");

endmodule
